>>> rtl/wse_pkg.sv
// ----------------------------------------------------------------------------
// wse_pkg
// Shared constants, register indexes and types of the ws2812 spi encoder.
// ----------------------------------------------------------------------------
package wse_pkg;

	localparam int PAD_WORDS_DEF  = 30;
	localparam int MAX_PIXELS_DEF = 1024;

	localparam int COLOR_W  = 8;
	localparam int WORD_W   = 24;
	localparam int COUNT_W  = 11;
	localparam int LANES    = 3;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SPLASH_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPLASH_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPLASH_COLOR  = 2'd2;

	// 100 repeated eight times
	localparam logic [WORD_W-1:0] LINE_ZERO_PATTERN = 24'h924924;

	typedef struct packed {
		logic [LANES-1:0][WORD_W-1:0] word;
		logic                         lead;
		logic                         last;
	} wse_item_t;

endpackage

>>> rtl/wse_lane.sv
// ----------------------------------------------------------------------------
// wse_lane
// One color lane: splash overlay select and 3-bit line encoding of a byte.
// ----------------------------------------------------------------------------
module wse_lane import wse_pkg::*; (
	input  logic [COLOR_W-1:0] pix,
	input  logic [COLOR_W-1:0] splash,
	input  logic               splash_en,
	input  logic               splash_hit,
	output logic [WORD_W-1:0]  word
);

	logic [COLOR_W-1:0] sel;

	always_comb begin
		if (!splash_en) begin
			sel = pix;
		end else if (splash_hit) begin
			sel = splash;
		end else begin
			sel = '0;
		end
	end

	always_comb begin
		word = LINE_ZERO_PATTERN;
		for (int i = 0; i < COLOR_W; i++) begin
			word[3*i+1] = sel[i];
		end
	end

endmodule

>>> rtl/wse_emit.sv
// ----------------------------------------------------------------------------
// wse_emit
// Merges the lane words of one pixel with lead-in and latch padding into a
// stream of words, one per cycle while the output is not stalled, through a registered output.
// ----------------------------------------------------------------------------
module wse_emit import wse_pkg::*; #(
	parameter int PAD_WORDS = PAD_WORDS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  wse_item_t         item,
	output logic              take,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [WORD_W-1:0] spi_word,
	output logic              run_last,
	output logic              frame_last
);

	localparam int CNT_W = ($clog2(PAD_WORDS) > 2) ? $clog2(PAD_WORDS) : 2;
	localparam logic [CNT_W-1:0] PAD_LAST   = CNT_W'(PAD_WORDS - 1);
	localparam logic [CNT_W-1:0] COLOR_LAST = CNT_W'(LANES - 1);

	localparam logic [1:0] PH_LEAD  = 2'd0;
	localparam logic [1:0] PH_COLOR = 2'd1;
	localparam logic [1:0] PH_LATCH = 2'd2;

	logic [1:0]       phase_q;
	logic [CNT_W-1:0] cnt_q;
	logic             cur_valid_q;
	wse_item_t        cur_q;
	logic             out_valid_q;
	logic [WORD_W-1:0] word_q;
	logic             run_last_q;
	logic             frame_last_q;

	logic              adv;
	logic              last_word;
	logic              load;
	logic [WORD_W-1:0] word_d;
	logic              run_last_d;
	logic              frame_last_d;

	always_comb begin
		word_d       = '0;
		run_last_d   = 1'b0;
		frame_last_d = 1'b0;
		last_word    = 1'b0;
		unique case (phase_q)
			PH_LEAD: begin
			end
			PH_COLOR: begin
				case (cnt_q[1:0])
					2'd0:    word_d = cur_q.word[0];
					2'd1:    word_d = cur_q.word[1];
					default: word_d = cur_q.word[2];
				endcase
				run_last_d = (cnt_q == COLOR_LAST) && !cur_q.last;
				last_word  = run_last_d;
			end
			PH_LATCH: begin
				run_last_d   = (cnt_q == PAD_LAST);
				frame_last_d = run_last_d;
				last_word    = run_last_d;
			end
			default: begin
			end
		endcase
	end

	assign adv  = cur_valid_q && (!out_valid_q || !out_stall);
	assign take = !cur_valid_q || (adv && last_word);
	assign load = take && item_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			phase_q     <= PH_LEAD;
			cnt_q       <= '0;
		end else if (load) begin
			cur_valid_q <= 1'b1;
			phase_q     <= item.lead ? PH_LEAD : PH_COLOR;
			cnt_q       <= '0;
		end else if (adv && last_word) begin
			cur_valid_q <= 1'b0;
		end else if (adv) begin
			if (phase_q == PH_LEAD && cnt_q == PAD_LAST) begin
				phase_q <= PH_COLOR;
				cnt_q   <= '0;
			end else if (phase_q == PH_COLOR && cnt_q == COLOR_LAST) begin
				phase_q <= PH_LATCH;
				cnt_q   <= '0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			word_q       <= word_d;
			run_last_q   <= run_last_d;
			frame_last_q <= frame_last_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign spi_word   = word_q;
	assign run_last   = run_last_q;
	assign frame_last = frame_last_q;

endmodule

>>> rtl/ws2812_spi_frame_encoder_core.sv
// ----------------------------------------------------------------------------
// ws2812_spi_frame_encoder_core
// Pixel to WS2812 SPI word encoder with frame padding and splash overlay.
// ----------------------------------------------------------------------------
// Each accepted pixel gives three 24-bit words (red, green, blue), one word
// per cycle while the output is not stalled; the first pixel of a frame adds
// PAD_WORDS lead-in words and the frame-end pixel adds PAD_WORDS latch words.
// The rate is set by the single output word register. Three lanes encode the
// color bytes in parallel in the cycle a pixel is taken, a one-pixel buffer
// holds the next pixel while the current one, in the emitter's current-pixel
// register, is sent through the output word register. Splash registers must be
// written only while the block is idle; the block itself does not enforce it.
module ws2812_spi_frame_encoder_core import wse_pkg::*; #(
	parameter int PAD_WORDS  = PAD_WORDS_DEF,
	parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [COLOR_W-1:0]   red,
	input  logic [COLOR_W-1:0]   green,
	input  logic [COLOR_W-1:0]   blue,
	input  logic                 frame_end,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [WORD_W-1:0]    spi_word,
	output logic                 run_last,
	output logic                 frame_last
);

	localparam int POS_W = $clog2(MAX_PIXELS + 1);
	localparam int CMP_W = (POS_W > COUNT_W) ? POS_W : COUNT_W;

	logic               splash_enable_q;
	logic [COUNT_W-1:0] splash_count_q;
	logic [WORD_W-1:0]  splash_color_q;
	logic [POS_W-1:0]   pos_q;

	logic                            accept;
	logic                            take;
	logic                            splash_hit;
	logic [LANES-1:0][COLOR_W-1:0]   pix;
	logic [LANES-1:0][COLOR_W-1:0]   splash;
	logic [LANES-1:0][WORD_W-1:0]    lane_word;
	wse_item_t                       item_d;
	wse_item_t                       item_s1;
	logic                            valid_s1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			splash_enable_q <= 1'b0;
			splash_count_q  <= '0;
			splash_color_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SPLASH_ENABLE: splash_enable_q <= cfg_data[0];
				REG_SPLASH_COUNT:  splash_count_q  <= cfg_data[COUNT_W-1:0];
				REG_SPLASH_COLOR:  splash_color_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign accept     = in_valid && !in_stall;
	assign in_stall   = valid_s1 && !take;
	assign splash_hit = CMP_W'(pos_q) < CMP_W'(splash_count_q);

	assign pix[0]    = red;
	assign pix[1]    = green;
	assign pix[2]    = blue;
	assign splash[0] = splash_color_q[23:16];
	assign splash[1] = splash_color_q[15:8];
	assign splash[2] = splash_color_q[7:0];

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		wse_lane u_lane (
			.pix        (pix[l]),
			.splash     (splash[l]),
			.splash_en  (splash_enable_q),
			.splash_hit (splash_hit),
			.word       (lane_word[l])
		);
	end

	always_comb begin
		item_d.word = lane_word;
		item_d.lead = (pos_q == '0);
		item_d.last = frame_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			if (frame_end) begin
				pos_q <= '0;
			end else if (pos_q < POS_W'(MAX_PIXELS)) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_d;
		end
	end

	wse_emit #(
		.PAD_WORDS (PAD_WORDS)
	) u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s1),
		.item       (item_s1),
		.take       (take),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.spi_word   (spi_word),
		.run_last   (run_last),
		.frame_last (frame_last)
	);

endmodule

>>> rtl/wse_chk.sv
// ----------------------------------------------------------------------------
// wse_chk
// Port-level checks of the ws2812 spi encoder output stream.
// ----------------------------------------------------------------------------
module wse_chk import wse_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 cfg_valid,
	input logic                 cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [WORD_W-1:0]    cfg_data,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic [COLOR_W-1:0]   red,
	input logic [COLOR_W-1:0]   green,
	input logic [COLOR_W-1:0]   blue,
	input logic                 frame_end,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [WORD_W-1:0]    spi_word,
	input logic                 run_last,
	input logic                 frame_last
);

	// latch end closes the run of its pixel
	a_frame_last_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_last |-> run_last)
		else $error("frame_last without run_last");

	// the last latch word is zero
	a_frame_last_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_last |-> spi_word == '0)
		else $error("nonzero latch word");

	// blue word closing a pixel carries the line pattern
	a_run_last_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && run_last && !frame_last |->
			(spi_word & LINE_ZERO_PATTERN) == LINE_ZERO_PATTERN)
		else $error("run_last word is not an encoded byte");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(spi_word)
			&& $stable(run_last) && $stable(frame_last))
		else $error("stalled word changed");

endmodule

bind ws2812_spi_frame_encoder_core wse_chk u_wse_chk (.*);
